### hw/rtl/stmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stmf_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int CHANNELS     = 3;
	localparam int EXCL_WIDTH   = 2;

	// channel slots of the x, y and z words
	localparam int CH_X = 0;
	localparam int CH_Y = 1;
	localparam int CH_Z = 2;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [EXCL_WIDTH-1:0] excl_t;

	localparam excl_t EXCL_RESET = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANK,
		ST_DIV_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic shift;
		logic acc_clr;
		logic acc_en;
		logic div_start;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/stmf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module stmf_div #(
	parameter int SUM_WIDTH = 19,
	parameter int KEPT_W    = 3
) (
	input  wire logic                        clk,
	input  wire logic                        start,
	input  wire logic                        step,
	input  wire logic signed [SUM_WIDTH-1:0] dividend,
	input  wire logic [KEPT_W-1:0]           divisor,
	output stmf_pkg::sample_t                quotient
);
	import stmf_pkg::*;

	logic                 neg_q;
	logic [SUM_WIDTH-1:0] dvd_q;
	logic [KEPT_W-1:0]    rem_q;
	logic [KEPT_W-1:0]    dsr_q;

	logic [KEPT_W:0]       trial;
	logic [KEPT_W:0]       diff;
	logic                  ge;
	logic [SAMPLE_WIDTH-1:0] mag;

	// restoring division on the magnitude, one quotient bit per step
	always_comb begin
		trial = {rem_q, dvd_q[SUM_WIDTH-1]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_WIDTH-1];
			dvd_q <= dividend[SUM_WIDTH-1] ? unsigned'(-dividend) : unsigned'(dividend);
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step) begin
			rem_q <= ge ? diff[KEPT_W-1:0] : trial[KEPT_W-1:0];
			dvd_q <= {dvd_q[SUM_WIDTH-2:0], ge};
		end
	end

	// dividend bits have all shifted out, dvd_q now holds the quotient
	assign mag      = dvd_q[SAMPLE_WIDTH-1:0];
	assign quotient = sample_t'(neg_q ? (~mag + 1'b1) : mag);

endmodule

`default_nettype wire

### hw/rtl/stmf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module stmf_datapath #(
	parameter int WINDOW_DEPTH = 5,
	parameter int SUM_WIDTH    = 19
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire stmf_pkg::excl_t               cfg_wr_data,
	input  wire stmf_pkg::sample_t             sample [stmf_pkg::CHANNELS],
	input  wire stmf_pkg::dp_cmd_t             cmd,
	input  wire logic [$clog2(WINDOW_DEPTH)-1:0] idx,
	output stmf_pkg::sample_t                  result [stmf_pkg::CHANNELS]
);
	import stmf_pkg::*;

	localparam int IDX_W    = $clog2(WINDOW_DEPTH);
	localparam int KEPT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int MAX_TRIM = (WINDOW_DEPTH - 1) / 2;
	localparam logic signed [SUM_WIDTH-1:0] ACC_MAX =
		SUM_WIDTH'(WINDOW_DEPTH * (2 ** (SAMPLE_WIDTH - 1) - 1));
	localparam logic signed [SUM_WIDTH-1:0] ACC_MIN =
		SUM_WIDTH'(-(WINDOW_DEPTH * (2 ** (SAMPLE_WIDTH - 1))));

	excl_t excl_q;

	sample_t win_q [CHANNELS][WINDOW_DEPTH];
	logic signed [SUM_WIDTH-1:0] acc_q [CHANNELS];
	sample_t result_q [CHANNELS];

	logic [KEPT_W-1:0] trim;
	logic [KEPT_W-1:0] hi_bound;
	logic [KEPT_W-1:0] kept;

	sample_t          sel  [CHANNELS];
	logic [IDX_W-1:0] rank [CHANNELS];
	logic             keep [CHANNELS];
	sample_t          quot [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excl_q <= EXCL_RESET;
		end else if (cfg_wr_en) begin
			excl_q <= cfg_wr_data;
		end
	end

	// trim saturates so that at least one sample stays
	always_comb begin
		trim = (KEPT_W'(excl_q) > KEPT_W'(MAX_TRIM)) ? KEPT_W'(MAX_TRIM) : KEPT_W'(excl_q);
		hi_bound = KEPT_W'(WINDOW_DEPTH) - trim;
		kept     = hi_bound - trim;
	end

	// window, newest sample at slot 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int k = 0; k < WINDOW_DEPTH; k++) begin
					win_q[c][k] <= '0;
				end
			end
		end else if (cmd.shift) begin
			for (int c = 0; c < CHANNELS; c++) begin
				win_q[c][0] <= sample[c];
				for (int k = 1; k < WINDOW_DEPTH; k++) begin
					win_q[c][k] <= win_q[c][k-1];
				end
			end
		end
	end

	// sorted position of the selected sample, ties broken by slot
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			sel[c]  = win_q[c][idx];
			rank[c] = '0;
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				if (win_q[c][i] < sel[c] || (win_q[c][i] == sel[c] && IDX_W'(i) < idx)) begin
					rank[c] = rank[c] + IDX_W'(1);
				end
			end
			keep[c] = (KEPT_W'(rank[c]) >= trim) && (KEPT_W'(rank[c]) < hi_bound);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++) begin
			if (cmd.acc_clr) begin
				acc_q[c] <= '0;
			end else if (cmd.acc_en && keep[c]) begin
				acc_q[c] <= acc_q[c] + {{(SUM_WIDTH - SAMPLE_WIDTH){sel[c][SAMPLE_WIDTH-1]}}, sel[c]};
			end
			if (cmd.load_out) begin
				result_q[c] <= quot[c];
			end
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_div
		stmf_div #(
			.SUM_WIDTH (SUM_WIDTH),
			.KEPT_W    (KEPT_W)
		) u_div (
			.clk      (clk),
			.start    (cmd.div_start),
			.step     (cmd.div_step),
			.dividend (acc_q[c]),
			.divisor  (kept),
			.quotient (quot[c])
		);
	end

	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_kept_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (kept != '0 && kept <= KEPT_W'(WINDOW_DEPTH)))
		else $error("kept count out of range");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (acc_q[CH_X] <= ACC_MAX && acc_q[CH_X] >= ACC_MIN))
		else $error("trimmed sum out of range");
`endif

endmodule

`default_nettype wire

### hw/rtl/stmf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stmf_ctrl #(
	parameter int WINDOW_DEPTH = 5,
	parameter int SUM_WIDTH    = 19
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output stmf_pkg::dp_cmd_t                    cmd,
	output logic [$clog2(WINDOW_DEPTH)-1:0]      idx
);
	import stmf_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(SUM_WIDTH);
	localparam logic [CNT_W-1:0] RANK_LAST = CNT_W'(WINDOW_DEPTH - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SUM_WIDTH - 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.shift   = 1'b1;
					cmd.acc_clr = 1'b1;
					cnt_d       = '0;
					state_d     = ST_RANK;
				end
			end
			ST_RANK: begin
				cmd.acc_en = 1'b1;
				if (cnt_q == RANK_LAST) begin
					cnt_d   = '0;
					state_d = ST_DIV_LOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				// hold the result until the output register frees up
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign idx       = cnt_q[IDX_W-1:0];

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output word overwritten before taken");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_RANK && cnt_q == '0))
		else $error("accepted word did not start a rank pass");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK) |-> (cnt_q <= RANK_LAST))
		else $error("rank index past window");
`endif

endmodule

`default_nettype wire

### hw/rtl/sliding_trimmed_mean_filter.sv
// Trimmed moving-average filter for three signed sample channels.
// Input channel: in_valid/in_ready with sample_x, sample_y, sample_z; a word
// is taken when both are high. Output channel: out_valid/out_ready with
// filtered_x, filtered_y, filtered_z; one output word per input word.
// Each channel keeps a window of the last WINDOW_DEPTH samples, drops the
// exclude_count smallest and largest and outputs the mean of the rest,
// truncated toward zero. exclude_count is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. Values above (WINDOW_DEPTH-1)/2 act
// as (WINDOW_DEPTH-1)/2. After a word is taken, the rank pass walks the
// window one slot a cycle, then a radix-2 divider takes one sum bit a
// cycle, and the result is loaded into the output register as out_valid
// rises. A new word is taken only once the previous result is in the
// output register, so in_ready is high again while a result still
// waits; if the receiver stalls the next result is held inside until the
// output register is free. Reset clears the windows to zero, sets
// exclude_count to 2 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module sliding_trimmed_mean_filter #(
	parameter int WINDOW_DEPTH = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire stmf_pkg::sample_t  sample_x,
	input  wire stmf_pkg::sample_t  sample_y,
	input  wire stmf_pkg::sample_t  sample_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output stmf_pkg::sample_t       filtered_x,
	output stmf_pkg::sample_t       filtered_y,
	output stmf_pkg::sample_t       filtered_z,
	input  wire logic               cfg_wr_en,
	input  wire stmf_pkg::excl_t    cfg_wr_data
);
	import stmf_pkg::*;

	localparam int SUM_WIDTH = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);
	localparam int IDX_W     = $clog2(WINDOW_DEPTH);

	dp_cmd_t          cmd;
	logic [IDX_W-1:0] idx;
	sample_t          samp [CHANNELS];
	sample_t          res  [CHANNELS];

	assign samp[CH_X] = sample_x;
	assign samp[CH_Y] = sample_y;
	assign samp[CH_Z] = sample_z;

	stmf_ctrl #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SUM_WIDTH    (SUM_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.idx       (idx)
	);

	stmf_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SUM_WIDTH    (SUM_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample      (samp),
		.cmd         (cmd),
		.idx         (idx),
		.result      (res)
	);

	assign filtered_x = res[CH_X];
	assign filtered_y = res[CH_Y];
	assign filtered_z = res[CH_Z];

endmodule

`default_nettype wire

### tb/sv/tb_sliding_trimmed_mean_filter.sv
`timescale 1ns / 1ps

module tb_sliding_trimmed_mean_filter;
	import stmf_pkg::*;

	localparam int WIN       = 5;
	localparam int MAX_TRIM  = (WIN - 1) / 2;
	localparam int STALL_MAX = 4000;
	localparam int N_DIR     = 20;
	localparam int N_PHASES  = 6;
	localparam int PHASE_LEN = 175;

	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
	} xyz_t;

	typedef struct packed {
		logic  cfg_en;
		excl_t cfg_val;
		xyz_t  smp;
		logic  exp_en;
		xyz_t  exp_w;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t sample_x = '0;
	sample_t sample_y = '0;
	sample_t sample_z = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	sample_t filtered_x;
	sample_t filtered_y;
	sample_t filtered_z;
	logic    cfg_wr_en = 1'b0;
	excl_t   cfg_wr_data = '0;

	// predictor state
	sample_t window_q [CHANNELS][WIN];
	excl_t   excl_reg = EXCL_RESET;

	xyz_t pending_means [$];
	int   errors = 0;
	int   quiet_cycles = 0;
	logic calm = 1'b0;

	// one row per word; expected word typed in only where it is obvious
	dir_row_t dir_rows [N_DIR] = '{
		// reset zeros dominate the median until the third word
		'{1'b0, 2'd0, '{32767, -32768, 1}, 1'b1, '{0, 0, 0}},
		'{1'b0, 2'd0, '{32767, -32768, 1}, 1'b1, '{0, 0, 0}},
		'{1'b0, 2'd0, '{32767, -32768, 1}, 1'b1, '{32767, -32768, 1}},
		'{1'b0, 2'd0, '{32767, -32768, 1}, 1'b1, '{32767, -32768, 1}},
		'{1'b0, 2'd0, '{32767, -32768, 1}, 1'b1, '{32767, -32768, 1}},
		// plain mean over the whole window
		'{1'b1, 2'd0, '{-32768, 32767, -1}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{-32768, 32767, -1}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{-32768, 32767, -1}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{-32768, 32767, -1}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{-32768, 32767, -1}, 1'b1, '{-32768, 32767, -1}},
		'{1'b1, 2'd1, '{0, 0, -2}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{-1, 1, -3}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{21845, -21846, 4660}, 1'b0, '{0, 0, 0}},
		// trim count above the window limit
		'{1'b1, 2'd3, '{-21846, 21845, -4661}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{100, -100, 7}, 1'b0, '{0, 0, 0}},
		// small negative sums, truncation toward zero
		'{1'b1, 2'd0, '{-1, -1, -1}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{-2, 1, -1}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{-1, 0, -4}, 1'b0, '{0, 0, 0}},
		'{1'b1, 2'd2, '{0, 0, 0}, 1'b0, '{0, 0, 0}},
		'{1'b0, 2'd0, '{-7, 7, 0}, 1'b0, '{0, 0, 0}}
	};

	excl_t phase_excl [N_PHASES] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3};

	sliding_trimmed_mean_filter #(
		.WINDOW_DEPTH(WIN)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_x   (sample_x),
		.sample_y   (sample_y),
		.sample_z   (sample_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered_x (filtered_x),
		.filtered_y (filtered_y),
		.filtered_z (filtered_z),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// shifts the new samples into the windows and returns the trimmed means
	function automatic xyz_t push_and_filter(xyz_t s);
		sample_t fresh [CHANNELS];
		int      means [CHANNELS];
		int      ranked [WIN];
		int      trim;
		int      key;
		int      j;
		int      sum;
		xyz_t    r;
		fresh[CH_X] = s.x;
		fresh[CH_Y] = s.y;
		fresh[CH_Z] = s.z;
		trim = (int'(excl_reg) > MAX_TRIM) ? MAX_TRIM : int'(excl_reg);
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int k = WIN - 1; k > 0; k--)
				window_q[ch][k] = window_q[ch][k-1];
			window_q[ch][0] = fresh[ch];
			for (int k = 0; k < WIN; k++)
				ranked[k] = int'(window_q[ch][k]);
			for (int i = 1; i < WIN; i++) begin
				key = ranked[i];
				j = i - 1;
				while (j >= 0 && ranked[j] > key) begin
					ranked[j+1] = ranked[j];
					j--;
				end
				ranked[j+1] = key;
			end
			sum = 0;
			for (int k = trim; k < WIN - trim; k++)
				sum += ranked[k];
			means[ch] = sum / (WIN - 2 * trim);
		end
		r.x = sample_t'(means[CH_X]);
		r.y = sample_t'(means[CH_Y]);
		r.z = sample_t'(means[CH_Z]);
		return r;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return sample_t'(-32768);
			1: return sample_t'(32767);
			2, 3: return sample_t'(int'($urandom_range(0, 14)) - 7);
			4: return $urandom_range(0, 1) ? sample_t'(-32767) : sample_t'(32766);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_word(xyz_t s, logic typed, xyz_t typed_w);
		xyz_t predicted;
		while (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_x <= s.x;
		sample_y <= s.y;
		sample_z <= s.z;
		do @(posedge clk); while (!in_ready);
		predicted = push_and_filter(s);
		pending_means.push_back(typed ? typed_w : predicted);
		@(negedge clk);
	endtask

	task automatic write_excl(excl_t v);
		in_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		excl_reg = v;
	endtask

	always @(negedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
	end

	always @(posedge clk) begin
		xyz_t want;
		if (out_valid && out_ready) begin
			if (pending_means.size() == 0) begin
				$error("output word with nothing expected: %0d %0d %0d",
					filtered_x, filtered_y, filtered_z);
				errors++;
			end else begin
				want = pending_means.pop_front();
				if (filtered_x !== want.x) begin
					$error("filtered_x: expected %0d, got %0d", want.x, filtered_x);
					errors++;
				end
				if (filtered_y !== want.y) begin
					$error("filtered_y: expected %0d, got %0d", want.y, filtered_y);
					errors++;
				end
				if (filtered_z !== want.z) begin
					$error("filtered_z: expected %0d, got %0d", want.z, filtered_z);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		xyz_t s;
		for (int ch = 0; ch < CHANNELS; ch++)
			for (int k = 0; k < WIN; k++)
				window_q[ch][k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].cfg_en)
				write_excl(dir_rows[i].cfg_val);
			send_word(dir_rows[i].smp, dir_rows[i].exp_en, dir_rows[i].exp_w);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			write_excl(phase_excl[p]);
			// one phase runs with no idling on either side
			calm = (p == 2);
			for (int n = 0; n < PHASE_LEN; n++) begin
				s.x = pick_sample();
				s.y = pick_sample();
				s.z = pick_sample();
				send_word(s, 1'b0, '0);
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
hw/rtl/stmf_pkg.sv
hw/rtl/stmf_div.sv
hw/rtl/stmf_datapath.sv
hw/rtl/stmf_ctrl.sv
hw/rtl/sliding_trimmed_mean_filter.sv
tb/sv/tb_sliding_trimmed_mean_filter.sv
